// ===== rtl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types, constants and the control store of the day count to calendar
// date unit.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int NUM_W   = 16;
  localparam int POS_W   = NUM_W + 1;
  localparam int REM_W   = 7;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = YEAR_W;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd16383;
  localparam logic [YEAR_W-1:0]  YEAR_RESET   = 14'd2014;
  localparam logic [YEAR_W-1:0]  CENTURY      = 14'd100;
  localparam logic [REM_W-1:0]   CENTURY_LAST = 7'd99;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_RESET = MONTH_APR;

  localparam logic [DAY_W-1:0] LEN_LONG   = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT  = 5'd30;
  localparam logic [DAY_W-1:0] LEN_FEB    = 5'd28;
  localparam logic [DAY_W-1:0] LEN_FEB_LP = 5'd29;
  localparam logic [DAY_W-1:0] DAY_RESET  = 5'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BASE_YEAR  = 2'd0;
  localparam logic [IDX_W-1:0] REG_BASE_MONTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_DAY   = 2'd2;

  // step addresses of the control program
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_IDLE = 2'd0;
  localparam logic [STEP_W-1:0] STEP_DIV  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_WALK = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DIV,
    OP_WALK
  } op_t;

  typedef enum logic [1:0] {
    COND_START,
    COND_GE_CENTURY,
    COND_WALK_END
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] jump_to;
    logic [STEP_W-1:0] fall_to;
  } ctrl_t;

  // calendar state that the month length depends on
  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [REM_W-1:0]   year_rem100;
    logic [1:0]         century_mod4;
  } cal_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      STEP_IDLE: w = '{op: OP_LOAD, cond: COND_START,
                       jump_to: STEP_DIV, fall_to: STEP_IDLE};
      STEP_DIV:  w = '{op: OP_DIV, cond: COND_GE_CENTURY,
                       jump_to: STEP_DIV, fall_to: STEP_WALK};
      STEP_WALK: w = '{op: OP_WALK, cond: COND_WALK_END,
                       jump_to: STEP_IDLE, fall_to: STEP_WALK};
      default:   w = '{op: OP_LOAD, cond: COND_START,
                       jump_to: STEP_IDLE, fall_to: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/day_count_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_unit
// Gregorian date of a one-based day number counted from a configured base date.
// ----------------------------------------------------------------------------
// Usage:
//   Configure base_year, base_month and base_day through cfg_write, cfg_index
//   and cfg_data while the unit is idle. Present a day_number with start; the
//   word is taken at a rising edge where start is high and busy is low.
//   busy rises the next cycle and stays high until the result is out.
//   The result (year, month, day_of_month) appears with done high for exactly
//   one cycle; the receiver cannot stall, so it must capture it then.
// Timing:
//   A small control program steps a shared datapath. After acceptance the
//   base year is split into centuries, one subtraction of 100 per cycle,
//   then the walk advances one month per cycle until the remaining day
//   count fits the month or the walk saturates at the last year. done
//   rises in the cycle after the last walk step; busy is already low while
//   done is high, so a new word can be taken at the edge that ends the
//   done cycle.
// Reset:
//   rst (synchronous, active high) returns the program to its idle step,
//   drops any word in flight and restores the base date 2014-04-02.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dcd_pkg::NUM_W-1:0]     day_number,
  output logic                          done,
  output logic [dcd_pkg::YEAR_W-1:0]    year,
  output logic [dcd_pkg::MONTH_W-1:0]   month,
  output logic [dcd_pkg::DAY_W-1:0]     day_of_month,
  input  logic                          cfg_write,
  input  logic [dcd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dcd_pkg::DATA_W-1:0]    cfg_data
);

  // configuration
  logic [dcd_pkg::YEAR_W-1:0]  base_year;
  logic [dcd_pkg::MONTH_W-1:0] base_month;
  logic [dcd_pkg::DAY_W-1:0]   base_day;

  // sequencer
  logic [dcd_pkg::STEP_W-1:0] step;
  logic [dcd_pkg::STEP_W-1:0] step_next;
  dcd_pkg::ctrl_t             ctrl;
  logic                       cond_hit;

  // datapath
  logic [dcd_pkg::YEAR_W-1:0]  cur_year;
  logic [dcd_pkg::YEAR_W-1:0]  year_tmp;
  logic [dcd_pkg::MONTH_W-1:0] cur_month;
  logic [dcd_pkg::POS_W-1:0]   pos;
  logic [dcd_pkg::REM_W-1:0]   rem100;
  logic [1:0]                  cent4;
  dcd_pkg::cal_t               cal;
  logic [dcd_pkg::DAY_W-1:0]   len;
  logic                        fits;
  logic                        sat;

  // sanitized load values
  logic [dcd_pkg::YEAR_W-1:0]  load_year;
  logic [dcd_pkg::MONTH_W-1:0] load_month;
  logic [dcd_pkg::DAY_W-1:0]   load_day;
  logic [dcd_pkg::NUM_W-1:0]   load_num;

  assign load_year  = (base_year == '0) ? dcd_pkg::YEAR_W'(1) : base_year;
  assign load_month = (base_month == '0) ? dcd_pkg::MONTH_JAN :
                      (base_month > dcd_pkg::MONTH_DEC) ? dcd_pkg::MONTH_DEC :
                      base_month;
  assign load_day   = (base_day == '0) ? dcd_pkg::DAY_W'(1) : base_day;
  assign load_num   = (day_number == '0) ? dcd_pkg::NUM_W'(1) : day_number;

  assign cal = '{month: cur_month, year_rem100: rem100, century_mod4: cent4};

  dcd_month_len u_month_len (
    .cal (cal),
    .len (len)
  );

  // the target day lies in this month, or the walk would pass the last year
  assign fits = (pos <= {{(dcd_pkg::POS_W-dcd_pkg::DAY_W){1'b0}}, len});
  assign sat  = !fits && (cur_month == dcd_pkg::MONTH_DEC) &&
                (cur_year == dcd_pkg::YEAR_MAX);

  // fetch the control word and resolve its jump
  assign ctrl = dcd_pkg::ucode(step);
  assign busy = (step != dcd_pkg::STEP_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      dcd_pkg::COND_START:      cond_hit = start;
      dcd_pkg::COND_GE_CENTURY: cond_hit = (year_tmp >= dcd_pkg::CENTURY);
      dcd_pkg::COND_WALK_END:   cond_hit = fits || sat;
      default:                  cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? ctrl.jump_to : ctrl.fall_to;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= dcd_pkg::STEP_IDLE;
      done       <= 1'b0;
      base_year  <= dcd_pkg::YEAR_RESET;
      base_month <= dcd_pkg::MONTH_RESET;
      base_day   <= dcd_pkg::DAY_RESET;
    end else begin
      step <= step_next;
      done <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          dcd_pkg::REG_BASE_YEAR:  base_year  <= cfg_data;
          dcd_pkg::REG_BASE_MONTH: base_month <= cfg_data[dcd_pkg::MONTH_W-1:0];
          dcd_pkg::REG_BASE_DAY:   base_day   <= cfg_data[dcd_pkg::DAY_W-1:0];
          default: ;
        endcase
      end

      // strobe the result on the last walk step
      if (ctrl.op == dcd_pkg::OP_WALK && cond_hit) begin
        done <= 1'b1;
      end
    end
  end

  // datapath, driven by the current control word
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      dcd_pkg::OP_LOAD: begin
        if (cond_hit) begin
          cur_year  <= load_year;
          year_tmp  <= load_year;
          cur_month <= load_month;
          cent4     <= 2'b00;
          // day position counted from the first of the base month
          pos <= {{(dcd_pkg::POS_W-dcd_pkg::DAY_W){1'b0}}, load_day} +
                 {1'b0, load_num} - dcd_pkg::POS_W'(1);
        end
      end
      dcd_pkg::OP_DIV: begin
        // strip one century per cycle, keep the century count mod 4
        if (cond_hit) begin
          year_tmp <= year_tmp - dcd_pkg::CENTURY;
          cent4    <= cent4 + 2'b01;
        end else begin
          rem100 <= year_tmp[dcd_pkg::REM_W-1:0];
        end
      end
      dcd_pkg::OP_WALK: begin
        if (fits) begin
          year         <= cur_year;
          month        <= cur_month;
          day_of_month <= pos[dcd_pkg::DAY_W-1:0];
        end else if (sat) begin
          year         <= dcd_pkg::YEAR_MAX;
          month        <= dcd_pkg::MONTH_DEC;
          day_of_month <= dcd_pkg::LEN_LONG;
        end else begin
          // drop this month's days and advance one month
          pos <= pos - {{(dcd_pkg::POS_W-dcd_pkg::DAY_W){1'b0}}, len};
          if (cur_month == dcd_pkg::MONTH_DEC) begin
            cur_month <= dcd_pkg::MONTH_JAN;
            cur_year  <= cur_year + dcd_pkg::YEAR_W'(1);
            if (rem100 == dcd_pkg::CENTURY_LAST) begin
              rem100 <= '0;
              cent4  <= cent4 + 2'b01;
            end else begin
              rem100 <= rem100 + dcd_pkg::REM_W'(1);
            end
          end else begin
            cur_month <= cur_month + dcd_pkg::MONTH_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dcd_month_len.sv =====
// ----------------------------------------------------------------------------
// dcd_month_len
// Length of the current month, with the leap rule taken from the year kept
// as a remainder modulo 100 and a century count modulo 4.
// ----------------------------------------------------------------------------
module dcd_month_len (
  input  dcd_pkg::cal_t              cal,
  output logic [dcd_pkg::DAY_W-1:0]  len
);

  logic leap;

  // the year is divisible by 4 exactly when its remainder mod 100 is
  assign leap = (cal.year_rem100 != '0) ? (cal.year_rem100[1:0] == 2'b00)
                                        : (cal.century_mod4 == 2'b00);

  always_comb begin
    case (cal.month) inside
      dcd_pkg::MONTH_FEB: len = leap ? dcd_pkg::LEN_FEB_LP : dcd_pkg::LEN_FEB;
      dcd_pkg::MONTH_APR, dcd_pkg::MONTH_JUN,
      dcd_pkg::MONTH_SEP, dcd_pkg::MONTH_NOV: len = dcd_pkg::LEN_SHORT;
      default: len = dcd_pkg::LEN_LONG;
    endcase
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the day count to calendar date unit. A driver feeds
// day numbers from a queue through the start/busy handshake, and a monitor
// predicts the Gregorian date of every accepted word and compares it with
// the one-cycle result marked by done. Base dates change only between phases
// while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic [dcd_pkg::YEAR_W-1:0]  year;
    logic [dcd_pkg::MONTH_W-1:0] month;
    logic [dcd_pkg::DAY_W-1:0]   dom;
  } cal_date_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [dcd_pkg::NUM_W-1:0]   day_number = '0;
  logic                        done;
  logic [dcd_pkg::YEAR_W-1:0]  year;
  logic [dcd_pkg::MONTH_W-1:0] month;
  logic [dcd_pkg::DAY_W-1:0]   day_of_month;
  logic                        cfg_write = 1'b0;
  logic [dcd_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [dcd_pkg::DATA_W-1:0]  cfg_data = '0;

  // Our copy of the base date, kept in step with every register write.
  logic [dcd_pkg::YEAR_W-1:0]  base_year_q  = dcd_pkg::YEAR_RESET;
  logic [dcd_pkg::MONTH_W-1:0] base_month_q = dcd_pkg::MONTH_RESET;
  logic [dcd_pkg::DAY_W-1:0]   base_day_q   = dcd_pkg::DAY_RESET;

  logic [dcd_pkg::NUM_W-1:0] pending_days[$];
  cal_date_t                 expected_dates[$];
  logic                      word_taken = 1'b0;
  int                        gap_left = 0;
  int                        idle_pct = 0;
  int                        quiet_cycles = 0;
  int                        error_count = 0;

  day_count_to_calendar_date_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .day_number   (day_number),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Walk month by month from the base month until the day count fits, the
  // same way the unit does. Out-of-range base fields are clamped first.
  function automatic cal_date_t date_of_day(input logic [dcd_pkg::NUM_W-1:0] n_in);
    int unsigned n;
    int unsigned y;
    int unsigned m;
    int unsigned pos;
    int unsigned len;
    bit          leap;
    bit          settled;
    cal_date_t   r;
    n = 32'(n_in);
    if (n == 0) n = 1;                          // day zero reads as the base date
    y = 32'(base_year_q);
    if (y == 0) y = 1;
    m = 32'(base_month_q);
    if (m == 0) m = 32'(dcd_pkg::MONTH_JAN);
    if (m > dcd_pkg::MONTH_DEC) m = 32'(dcd_pkg::MONTH_DEC);
    pos = 32'(base_day_q);
    if (pos == 0) pos = 1;
    // A base day past month end simply spills into the next months here.
    pos = pos + n - 1;
    settled = 1'b0;
    while (!settled) begin
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (m == dcd_pkg::MONTH_FEB)
        len = 32'(leap ? dcd_pkg::LEN_FEB_LP : dcd_pkg::LEN_FEB);
      else if (m == dcd_pkg::MONTH_APR || m == dcd_pkg::MONTH_JUN ||
               m == dcd_pkg::MONTH_SEP || m == dcd_pkg::MONTH_NOV)
        len = 32'(dcd_pkg::LEN_SHORT);
      else len = 32'(dcd_pkg::LEN_LONG);
      if (pos <= len) begin
        settled = 1'b1;
      end else begin
        pos = pos - len;
        m = m + 1;
        if (m > dcd_pkg::MONTH_DEC) begin
          if (y >= dcd_pkg::YEAR_MAX) begin
            // Walking past the last representable December pins the date.
            y = 32'(dcd_pkg::YEAR_MAX);
            m = 32'(dcd_pkg::MONTH_DEC);
            pos = 32'(dcd_pkg::LEN_LONG);
            settled = 1'b1;
          end else begin
            m = 32'(dcd_pkg::MONTH_JAN);
            y = y + 1;
          end
        end
      end
    end
    r.year  = y[dcd_pkg::YEAR_W-1:0];
    r.month = m[dcd_pkg::MONTH_W-1:0];
    r.dom   = pos[dcd_pkg::DAY_W-1:0];
    return r;
  endfunction

  // Driver: present words at the falling edge, hold start until the word is
  // taken, and drop start for random bursts when idling is enabled.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // hold the word until busy lets it in
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_days.size() != 0) begin
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 14);
      end else begin
        start <= 1'b1;
        day_number <= pending_days.pop_front();
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results against the oldest expectation, then log any word
  // accepted at this edge, and keep the watchdog running.
  always @(posedge clk) begin : monitor
    cal_date_t want;
    if (rst) begin
      word_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      word_taken <= start && !busy;
      if (done) begin
        if (expected_dates.size() == 0) begin
          $error("result with no word pending: %0d-%0d-%0d", year, month, day_of_month);
          error_count++;
        end else begin
          want = expected_dates.pop_front();
          if (year !== want.year) begin
            $error("year mismatch: expected %0d, actual %0d", want.year, year);
            error_count++;
          end
          if (month !== want.month) begin
            $error("month mismatch: expected %0d, actual %0d", want.month, month);
            error_count++;
          end
          if (day_of_month !== want.dom) begin
            $error("day_of_month mismatch: expected %0d, actual %0d", want.dom,
                   day_of_month);
            error_count++;
          end
        end
      end
      if (start && !busy) expected_dates.push_back(date_of_day(day_number));
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Write one register; the unit must be idle when this is called.
  task automatic write_reg(input logic [dcd_pkg::IDX_W-1:0]  idx,
                           input logic [dcd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      dcd_pkg::REG_BASE_YEAR:  base_year_q  = val[dcd_pkg::YEAR_W-1:0];
      dcd_pkg::REG_BASE_MONTH: base_month_q = val[dcd_pkg::MONTH_W-1:0];
      dcd_pkg::REG_BASE_DAY:   base_day_q   = val[dcd_pkg::DAY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_base_date(input int y, input int m, input int d);
    write_reg(dcd_pkg::REG_BASE_YEAR, y[dcd_pkg::DATA_W-1:0]);
    write_reg(dcd_pkg::REG_BASE_MONTH, m[dcd_pkg::DATA_W-1:0]);
    write_reg(dcd_pkg::REG_BASE_DAY, d[dcd_pkg::DATA_W-1:0]);
  endtask

  // Wait until every queued word is taken and every expected date is back.
  // Sampled at the rising edge, where start and the queues are settled.
  task automatic drain();
    @(posedge clk);
    while (pending_days.size() != 0 || start || gap_left != 0 ||
           expected_dates.size() != 0)
      @(posedge clk);
  endtask

  // Mostly full-range counts, with some short spans, mid-size counts and counts near the top.
  task automatic load_random_days(input int count);
    logic [dcd_pkg::NUM_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       n = dcd_pkg::NUM_W'($urandom_range(0, 64));
        1:       n = dcd_pkg::NUM_W'($urandom_range(0, 1) ?
                                     32'hFFFF - $urandom_range(0, 40) :
                                     $urandom_range(300, 800));
        default: n = dcd_pkg::NUM_W'($urandom_range(0, 16'hFFFF));
      endcase
      pending_days.push_back(n);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset base date 2014-04-02: zero count, month turn, full range, patterns.
    idle_pct = 30;
    pending_days = '{16'd0, 16'd1, 16'd2, 16'd29, 16'd30, 16'hFFFF, 16'hAAAA,
                     16'h5555};
    drain();

    // Leap February in a 400-year, then the century rule.
    set_base_date(2000, 2, 28);
    pending_days = '{16'd2, 16'd3, 16'd367};
    drain();
    set_base_date(1900, 2, 28);
    pending_days = '{16'd2};
    drain();
    set_base_date(2100, 12, 31);
    pending_days = '{16'd60};
    drain();

    // Zero base fields all clamp up to 0001-01-01.
    set_base_date(0, 0, 0);
    pending_days = '{16'd0, 16'd365, 16'd366};
    drain();

    // Base day past month end rolls into March; month above twelve clamps.
    set_base_date(2023, 2, 31);
    pending_days = '{16'd1};
    drain();
    set_base_date(2024, 15, 30);
    pending_days = '{16'd2, 16'd3};
    drain();

    // Top of the year range: the walk saturates past December 31.
    set_base_date(int'(dcd_pkg::YEAR_MAX), 12, 31);
    pending_days = '{16'd1, 16'd2, 16'hFFFF};
    drain();

    // Random base dates, including out-of-range fields and very late years.
    for (int phase = 0; phase < 6; phase++) begin
      set_base_date($urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                                              : $urandom_range(1, 9999),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
                                              : $urandom_range(1, 12),
                    $urandom_range(0, 31));
      idle_pct = (phase == 2) ? 0 : $urandom_range(10, 60);
      load_random_days(36);
      drain();
    end

    // Closing stretch without sender gaps.
    idle_pct = 0;
    set_base_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
    load_random_days(20);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $error("%0d expected dates never arrived", expected_dates.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dcd_pkg.sv
rtl/dcd_month_len.sv
rtl/day_count_to_calendar_date_unit.sv
tb/sv/tb_top.sv
